### sv/assert_macros.svh
// Assertion macros for the RTL files of the block-pair dot product.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define Q4BD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define Q4BD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/q4bd_pkg.sv
// Package for the block-pair dot product: widths, constants, unpacked fp32 type
// and the operand unpacking functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q4bd_pkg;

	localparam int BLOCK_LEN     = 32;
	localparam int CODE_W        = 4;
	localparam int CODE_OFFSET   = 8;
	localparam int WORD_CODES    = 16;
	localparam int DOT_W         = 13;
	localparam int NUM_LANES_DEF = 4;
	localparam int FP_W          = 32;
	localparam int MAN_W         = 24;
	localparam logic [FP_W-1:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [FP_W-1:0] POS_ZERO  = 32'h0000_0000;
	// An integer operand n is presented as n * 2^(150 - 127 - 23).
	localparam logic [7:0] INT_EXP = 8'd150;

	typedef struct packed {
		logic             sign;
		logic [7:0]       exp;   // effective biased exponent, 1 for subnormals
		logic [MAN_W-1:0] man;   // mantissa with the hidden bit made explicit
		logic             nan;
		logic             inf;
		logic             zero;
	} fp_op_t;

	function automatic fp_op_t fp_unpack(input logic [FP_W-1:0] b);
		fp_op_t r;
		r.sign = b[31];
		r.nan  = 1'b0;
		r.inf  = 1'b0;
		r.zero = 1'b0;
		if (b[30:23] == 8'd0) begin
			r.exp  = 8'd1;
			r.man  = {1'b0, b[22:0]};
			r.zero = (b[22:0] == 23'd0);
		end else begin
			r.exp = b[30:23];
			r.man = {1'b1, b[22:0]};
			if (b[30:23] == 8'hFF) begin
				r.nan = (b[22:0] != 23'd0);
				r.inf = (b[22:0] == 23'd0);
			end
		end
		return r;
	endfunction

	function automatic fp_op_t int_unpack(input logic signed [DOT_W-1:0] d);
		fp_op_t r;
		logic [DOT_W-1:0] mag;
		mag    = d[DOT_W-1] ? (~d + 1'b1) : d;
		r.sign = d[DOT_W-1];
		r.exp  = INT_EXP;
		r.man  = {{(MAN_W-DOT_W){1'b0}}, mag};
		r.nan  = 1'b0;
		r.inf  = 1'b0;
		r.zero = (mag == '0);
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/q4bd_lane.sv
// One lane of the code dot product: products of offset 4-bit code pairs, summed.
// Depends on q4bd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q4bd_lane
	import q4bd_pkg::*;
#(
	parameter int CODES = BLOCK_LEN / NUM_LANES_DEF
) (
	input  wire logic                         clk,
	input  wire logic [CODES*CODE_W-1:0]      x_codes,
	input  wire logic [CODES*CODE_W-1:0]      y_codes,
	output logic signed [DOT_W-1:0]           psum_s1
);

	logic signed [DOT_W-1:0] sum;

	always_comb begin
		logic signed [CODE_W:0] ca;
		logic signed [CODE_W:0] cb;
		logic signed [2*CODE_W+1:0] pr;
		sum = '0;
		for (int i = 0; i < CODES; i++) begin
			ca  = $signed({1'b0, x_codes[i*CODE_W +: CODE_W]}) - (CODE_W+1)'(CODE_OFFSET);
			cb  = $signed({1'b0, y_codes[i*CODE_W +: CODE_W]}) - (CODE_W+1)'(CODE_OFFSET);
			pr  = ca * cb;
			sum = sum + DOT_W'(pr);
		end
	end

	always_ff @(posedge clk) begin
		psum_s1 <= sum;
	end

endmodule
`default_nettype wire

### sv/q4bd_fmul.sv
// Two-stage IEEE binary32 multiplier, round to nearest even, subnormals kept.
// Takes unpacked operands from q4bd_pkg; any NaN result is the canonical quiet NaN.
`timescale 1ns / 1ps
`default_nettype none
module q4bd_fmul
	import q4bd_pkg::*;
(
	input  wire logic            clk,
	input  wire fp_op_t          a,
	input  wire fp_op_t          b,
	output logic [FP_W-1:0]      res_s2
);

	logic [2*MAN_W-1:0]  p_s1;
	logic signed [10:0]  e_s1;
	logic                sign_s1, nan_s1, inf_s1, zero_s1;

	always_ff @(posedge clk) begin
		p_s1    <= a.man * b.man;
		e_s1    <= $signed({3'b0, a.exp}) + $signed({3'b0, b.exp}) - 11'sd126;
		sign_s1 <= a.sign ^ b.sign;
		nan_s1  <= a.nan | b.nan | (a.inf & b.zero) | (a.zero & b.inf);
		inf_s1  <= a.inf | b.inf;
		zero_s1 <= a.zero | b.zero;
	end

	logic [5:0]          lz, sh;
	logic [2*MAN_W-1:0]  pn, t, msk;
	logic signed [10:0]  e, shw;
	logic [7:0]          ef;
	logic                lost, rnd;
	logic [30:0]         word;
	logic [FP_W-1:0]     res;

	always_comb begin
		lz = '0;
		for (int i = 0; i < 2*MAN_W; i++) begin
			if (p_s1[i]) lz = 6'(2*MAN_W-1-i);
		end
		pn  = p_s1 << lz;
		e   = e_s1 - $signed({5'b0, lz});
		shw = 11'sd1 - e;
		if (e < 11'sd1) begin
			sh = (shw > 11'sd48) ? 6'd48 : shw[5:0];
			ef = 8'd0;
		end else begin
			sh = '0;
			ef = e[7:0];
		end
		t    = pn >> sh;
		msk  = ~({(2*MAN_W){1'b1}} << sh);
		lost = |(pn & msk);
		rnd  = t[23] & ((|t[22:0]) | lost | t[24]);
		word = {ef, t[46:24]} + {30'b0, rnd};
		priority if (nan_s1)
			res = CANON_NAN;
		else if (inf_s1)
			res = {sign_s1, 8'hFF, 23'd0};
		else if (zero_s1)
			res = {sign_s1, 31'd0};
		else if (e > 11'sd254)
			res = {sign_s1, 8'hFF, 23'd0};
		else
			res = {sign_s1, word};
	end

	always_ff @(posedge clk) begin
		res_s2 <= res;
	end

endmodule
`default_nettype wire

### sv/q4bd_fadd.sv
// Two-stage IEEE binary32 adder, round to nearest even, subnormals kept.
// Depends on q4bd_pkg; any NaN result is the canonical quiet NaN.
`timescale 1ns / 1ps
`default_nettype none
module q4bd_fadd
	import q4bd_pkg::*;
(
	input  wire logic            clk,
	input  wire logic [FP_W-1:0] a_bits,
	input  wire logic [FP_W-1:0] b_bits,
	output logic [FP_W-1:0]      res_s2
);

	fp_op_t          a, b, big, sml;
	logic            sub;
	logic [7:0]      d;
	logic [4:0]      dc;
	logic [26:0]     am, bs, bfull, bm;
	logic [27:0]     s;

	always_comb begin
		a = fp_unpack(a_bits);
		b = fp_unpack(b_bits);
		if ({a.exp, a.man} >= {b.exp, b.man}) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		sub   = a.sign ^ b.sign;
		d     = big.exp - sml.exp;
		dc    = (d > 8'd27) ? 5'd27 : d[4:0];
		am    = {big.man, 3'b0};
		bfull = {sml.man, 3'b0};
		bs    = bfull >> dc;
		// Bits shifted out fold into the sticky position.
		bm    = bs | {26'b0, |(bfull & ~({27{1'b1}} << dc))};
		s     = sub ? ({1'b0, am} - {1'b0, bm}) : ({1'b0, am} + {1'b0, bm});
	end

	logic [27:0] s_s1;
	logic [7:0]  exp_s1;
	logic        sign_s1, zsign_s1, nan_s1, inf_s1, isign_s1;

	always_ff @(posedge clk) begin
		s_s1     <= s;
		exp_s1   <= big.exp;
		sign_s1  <= big.sign;
		zsign_s1 <= sub ? 1'b0 : a.sign;
		nan_s1   <= a.nan | b.nan | (a.inf & b.inf & sub);
		inf_s1   <= a.inf | b.inf;
		isign_s1 <= a.inf ? a.sign : b.sign;
	end

	logic [4:0]      lz, sh;
	logic [7:0]      lim;
	logic [26:0]     sn;
	logic [9:0]      e;
	logic            rnd;
	logic [30:0]     word;
	logic [FP_W-1:0] res;

	always_comb begin
		lz  = '0;
		for (int i = 0; i < 27; i++) begin
			if (s_s1[i]) lz = 5'(26-i);
		end
		lim = exp_s1 - 8'd1;
		sh  = ({3'b0, lz} < lim) ? lz : lim[4:0];
		if (s_s1[27]) begin
			sn = {s_s1[27:2], s_s1[1] | s_s1[0]};
			e  = {2'b0, exp_s1} + 10'd1;
		end else begin
			sn = s_s1[26:0] << sh;
			e  = sn[26] ? ({2'b0, exp_s1} - {5'b0, sh}) : 10'd0;
		end
		rnd  = sn[2] & (sn[1] | sn[0] | sn[3]);
		word = {e[7:0], sn[25:3]} + {30'b0, rnd};
		priority if (nan_s1)
			res = CANON_NAN;
		else if (inf_s1)
			res = {isign_s1, 8'hFF, 23'd0};
		else if (s_s1 == '0)
			res = {zsign_s1, 31'd0};
		else if (e > 10'd254)
			res = {sign_s1, 8'hFF, 23'd0};
		else
			res = {sign_s1, word};
	end

	always_ff @(posedge clk) begin
		res_s2 <= res;
	end

endmodule
`default_nettype wire

### sv/q4_block_dot_product_core.sv
// Q4_0 block-pair dot product with a running fp32 accumulator.
// A word on the last block pair is registered on the output from the adder result in S_AC,
// or later from the accumulator while the output register still holds an untaken word.
// A new block pair is taken only in S_IDLE, once the one before it has been through the shared
// two-stage fp32 multiplier (used twice per pair) and the two-stage fp32 adder.
// Reset: asynchronous, active low; the accumulator clears to +0.0 and no word is held.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module q4_block_dot_product_core
	import q4bd_pkg::*;
#(
	parameter int NUM_LANES = NUM_LANES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] x_scale,
	input  wire logic [31:0] y_scale,
	input  wire logic [63:0] x_codes_low,
	input  wire logic [63:0] x_codes_high,
	input  wire logic [63:0] y_codes_low,
	input  wire logic [63:0] y_codes_high,
	input  wire logic        last_block,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      dot_sum
);

	localparam int CODES = BLOCK_LEN / NUM_LANES;
	localparam int LW    = CODES * CODE_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_M1A  = 4'd1;
	localparam logic [3:0] S_M1B  = 4'd2;
	localparam logic [3:0] S_M2A  = 4'd3;
	localparam logic [3:0] S_M2B  = 4'd4;
	localparam logic [3:0] S_AA   = 4'd5;
	localparam logic [3:0] S_AB   = 4'd6;
	localparam logic [3:0] S_AC   = 4'd7;
	localparam logic [3:0] S_EMIT = 4'd8;

	logic [3:0]                 state_q;
	logic [FP_W-1:0]            xs_q, ys_q;
	logic [BLOCK_LEN*CODE_W-1:0] xc_q, yc_q;
	logic                       last_q;
	logic [FP_W-1:0]            acc_q;
	logic                       out_valid_q;
	logic [FP_W-1:0]            out_q;
	logic signed [DOT_W-1:0]    dot_q;
	logic                       accept, emit_ok, emit;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign dot_sum   = out_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			xs_q   <= x_scale;
			ys_q   <= y_scale;
			xc_q   <= {x_codes_high, x_codes_low};
			yc_q   <= {y_codes_high, y_codes_low};
			last_q <= last_block;
		end
	end

	// Lanes each take a contiguous slice of code pairs.
	logic signed [DOT_W-1:0] psum_s1 [NUM_LANES];

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		q4bd_lane #(.CODES(CODES)) u_lane (
			.clk     (clk),
			.x_codes (xc_q[g*LW +: LW]),
			.y_codes (yc_q[g*LW +: LW]),
			.psum_s1 (psum_s1[g])
		);
	end

	logic signed [DOT_W-1:0] merged;

	always_comb begin
		merged = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			merged = merged + psum_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_M1B) begin
			dot_q <= merged;
		end
	end

	// The multiplier forms the scale product first and the term second.
	fp_op_t          mul_a, mul_b;
	logic [FP_W-1:0] mul_res, add_res;

	always_comb begin
		if (state_q == S_M2A) begin
			mul_a = fp_unpack(mul_res);
			mul_b = int_unpack(dot_q);
		end else begin
			mul_a = fp_unpack(xs_q);
			mul_b = fp_unpack(ys_q);
		end
	end

	q4bd_fmul u_fmul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.res_s2 (mul_res)
	);

	q4bd_fadd u_fadd (
		.clk    (clk),
		.a_bits (acc_q),
		.b_bits (mul_res),
		.res_s2 (add_res)
	);

	assign emit_ok = !out_valid_q || !out_stall;
	assign emit    = emit_ok && ((state_q == S_AC && last_q) || state_q == S_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= POS_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_M1A;
				S_M1A:  state_q <= S_M1B;
				S_M1B:  state_q <= S_M2A;
				S_M2A:  state_q <= S_M2B;
				S_M2B:  state_q <= S_AA;
				S_AA:   state_q <= S_AB;
				S_AB:   state_q <= S_AC;
				S_AC: begin
					if (!last_q) begin
						acc_q   <= add_res;
						state_q <= S_IDLE;
					end else if (emit_ok) begin
						acc_q   <= POS_ZERO;
						state_q <= S_IDLE;
					end else begin
						// The adder output moves on, so a total that meets a full
						// output register is parked in the accumulator.
						acc_q   <= add_res;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						acc_q   <= POS_ZERO;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= (state_q == S_EMIT) ? acc_q : add_res;
		end
	end

	`Q4BD_ASSERT_NXT(a_accept_starts, accept, state_q == S_M1A, "accepted word did not start work")
	`Q4BD_ASSERT_NOW(a_emit_from_last, $rose(out_valid_q),
		($past(state_q) == S_AC || $past(state_q) == S_EMIT) && last_q,
		"output word without a last block pair")
	`Q4BD_ASSERT_NOW(a_acc_cleared, $rose(out_valid_q), acc_q == POS_ZERO,
		"accumulator not cleared after emission")
	`Q4BD_ASSERT_NOW(a_canon_nan, out_valid_q && out_q[30:23] == 8'hFF && out_q[22:0] != 23'd0,
		out_q == CANON_NAN, "non-canonical NaN on the output")

endmodule
`default_nettype wire
